// File: hdl/jpdq_pkg.sv
// Shared types and constants for the joystick press and direction qualifier.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package jpdq_pkg;

    // Stream payload widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;

    // Field widths that the interface fixes
    localparam int AXIS_W   = 12;
    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;
    localparam int ACT_W    = 4;
    localparam int DIR_W    = 3;
    localparam int PCT_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Divider: the quotient of a percentage is below 128, so seven steps suffice
    localparam int DIV_STEPS = PCT_W;
    localparam int DIV_CNT_W = 3;
    localparam int DIVIDEND_W = MS_W + PCT_W;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // Directions
    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

    // Actions
    localparam logic [ACT_W-1:0] ACT_NONE      = 4'd0;
    localparam logic [ACT_W-1:0] ACT_SELECT    = 4'd5;
    localparam logic [ACT_W-1:0] ACT_BACK      = 4'd6;
    localparam logic [ACT_W-1:0] ACT_BACK2     = 4'd7;
    localparam logic [ACT_W-1:0] ACT_HOLD_BASE = 4'd7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_CENTER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VERY_LONG_MS = 3'd5;

    // Configuration reset values
    localparam logic [AXIS_W-1:0] RST_AXIS_CENTER  = 12'd2048;
    localparam logic [AXIS_W-1:0] RST_DEAD_ZONE    = 12'd400;
    localparam logic [MS_W-1:0]   RST_REPEAT_MS    = 16'd200;
    localparam logic [MS_W-1:0]   RST_SHORT_MS     = 16'd40;
    localparam logic [MS_W-1:0]   RST_LONG_MS      = 16'd1000;
    localparam logic [MS_W-1:0]   RST_VERY_LONG_MS = 16'd2000;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // take the input transaction
        logic dir_en;    // register direction, hold time and repeat test
        logic eval_en;   // decide the action and update the press state
        logic div_load;  // start a percentage division
        logic div_sel;   // 0: long time, 1: very long time
        logic div_step;  // one divider step
        logic p1_save;   // keep the first percentage
        logic out_load;  // fill the output register
    } jpdq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_last;  // divider performs its final step this cycle
    } jpdq_status_t;

endpackage

`default_nettype wire

// File: hdl/jpdq_div.sv
// Iterative restoring divider for the hold percentages, one quotient bit a cycle.
// Depends on jpdq_pkg.
`default_nettype none

module jpdq_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire logic                               step,
    input  wire logic [jpdq_pkg::DIVIDEND_W-1:0]    dividend,
    input  wire logic [jpdq_pkg::MS_W-1:0]          divisor,
    output logic      [jpdq_pkg::PCT_W-1:0]         quotient,
    output logic                                    last
);
    import jpdq_pkg::*;

    logic [MS_W-1:0]      rem_reg, rem_next;
    logic [PCT_W-1:0]     sh_reg, sh_next;
    logic [MS_W-1:0]      dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MS_W:0]        trial;
    logic [MS_W:0]        diff;
    logic                 fits;

    // One step: bring down the next dividend bit and try to subtract.
    // The caller only uses the quotient when dividend < 128 * divisor, so the
    // partial remainder stays below the divisor and fits its width.
    always_comb
    begin
        trial    = {rem_reg, sh_reg[PCT_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = rem_reg;
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            rem_next = dividend[DIVIDEND_W-1:PCT_W];
            sh_next  = dividend[PCT_W-1:0];
            cnt_next = '0;
        end
        else if (step)
        begin
            rem_next = fits ? diff[MS_W-1:0] : trial[MS_W-1:0];
            sh_next  = {sh_reg[PCT_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        if (load)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = sh_reg;
    assign last     = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

`default_nettype wire

// File: hdl/jpdq_ctrl.sv
// Sequencing state machine of the qualifier: input acceptance, decision,
// two divider runs and the output register handshake. Depends on jpdq_pkg.
`default_nettype none

module jpdq_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    input  wire jpdq_pkg::jpdq_status_t  status,
    output jpdq_pkg::jpdq_cmd_t          cmd
);
    import jpdq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIR  = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_DIV1 = 3'd3;
    localparam logic [2:0] S_MID  = 3'd4;
    localparam logic [2:0] S_DIV2 = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DIR;
                end
            end
            S_DIR:
            begin
                cmd.dir_en = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval_en  = 1'b1;
                cmd.div_load = 1'b1;
                state_next   = S_DIV1;
            end
            S_DIV1:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_MID;
                end
            end
            S_MID:
            begin
                cmd.p1_save  = 1'b1;
                cmd.div_load = 1'b1;
                cmd.div_sel  = 1'b1;
                state_next   = S_DIV2;
            end
            S_DIV2:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// File: hdl/jpdq_dp.sv
// Datapath of the qualifier: configuration registers, input capture, direction
// test, press state, action decision, percentage divider and output register.
// Depends on jpdq_pkg and jpdq_div.
`default_nettype none

module jpdq_dp #(
    parameter int ADC_BITS = 12
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [jpdq_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [jpdq_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  wire logic [jpdq_pkg::S_TDATA_W-1:0]         s_tdata,
    output logic      [jpdq_pkg::M_TDATA_W-1:0]         m_tdata,
    input  wire jpdq_pkg::jpdq_cmd_t                    cmd,
    output jpdq_pkg::jpdq_status_t                      status
);
    import jpdq_pkg::*;

    // Significant axis bits kept from each sample
    localparam int AXW = (ADC_BITS < AXIS_W) ? ADC_BITS : AXIS_W;

    // Configuration
    logic [AXIS_W-1:0] axis_center_reg;
    logic [AXIS_W-1:0] dead_zone_reg;
    logic [MS_W-1:0]   repeat_ms_reg;
    logic [MS_W-1:0]   short_ms_reg;
    logic [MS_W-1:0]   long_ms_reg;
    logic [MS_W-1:0]   very_long_ms_reg;

    // Captured sample
    logic [AXW-1:0]    x_reg;
    logic [AXW-1:0]    y_reg;
    logic              btn_reg;
    logic [TIME_W-1:0] now_reg;

    // Press state
    logic              bd_reg, bd_next;
    logic [TIME_W-1:0] ps_reg, ps_next;
    logic              fb_reg, fb_next;
    logic              fbl_reg, fbl_next;
    logic [DIR_W-1:0]  ld_reg, ld_next;
    logic [TIME_W-1:0] lr_reg, lr_next;

    // Intermediate results
    logic [DIR_W-1:0]  dir_reg, dir_calc;
    logic [TIME_W-1:0] held_reg, held_calc;
    logic              rep_due_reg, rep_due_calc;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic              pge1_reg, pge2_reg;
    logic [PCT_W-1:0]  p1_reg, p2_calc;

    logic signed [AXIS_W:0] dx, dy;
    logic [AXIS_W:0]        ax_full, ay_full;
    logic [AXIS_W-1:0]      ax, ay;
    logic [TIME_W-1:0]      since_repeat;
    logic                   ge_short, ge_long, ge_vlong;

    logic [DIVIDEND_W-1:0]  dividend;
    logic [MS_W-1:0]        divisor;
    logic [PCT_W-1:0]       quotient;
    logic                   div_last;

    // Configuration writes; indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_center_reg  <= RST_AXIS_CENTER;
            dead_zone_reg    <= RST_DEAD_ZONE;
            repeat_ms_reg    <= RST_REPEAT_MS;
            short_ms_reg     <= RST_SHORT_MS;
            long_ms_reg      <= RST_LONG_MS;
            very_long_ms_reg <= RST_VERY_LONG_MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AXIS_CENTER:  axis_center_reg  <= cfg_wdata[AXIS_W-1:0];
                CFG_DEAD_ZONE:    dead_zone_reg    <= cfg_wdata[AXIS_W-1:0];
                CFG_REPEAT_MS:    repeat_ms_reg    <= cfg_wdata;
                CFG_SHORT_MS:     short_ms_reg     <= cfg_wdata;
                CFG_LONG_MS:      long_ms_reg      <= cfg_wdata;
                CFG_VERY_LONG_MS: very_long_ms_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Dead-zone test; the larger offset wins and a tie goes to the vertical axis
    always_comb
    begin
        dx      = $signed({1'b0, AXIS_W'(x_reg)}) - $signed({1'b0, axis_center_reg});
        dy      = $signed({1'b0, AXIS_W'(y_reg)}) - $signed({1'b0, axis_center_reg});
        ax_full = dx[AXIS_W] ? (AXIS_W+1)'(-dx) : dx;
        ay_full = dy[AXIS_W] ? (AXIS_W+1)'(-dy) : dy;
        ax      = ax_full[AXIS_W-1:0];
        ay      = ay_full[AXIS_W-1:0];
        if (ax < dead_zone_reg && ay < dead_zone_reg)
        begin
            dir_calc = DIR_NONE;
        end
        else if (ax > ay)
        begin
            dir_calc = (dx > 0) ? DIR_RIGHT : DIR_LEFT;
        end
        else
        begin
            dir_calc = (dy > 0) ? DIR_DOWN : DIR_UP;
        end
    end

    // Hold time (zero on the sample that starts a press) and repeat interval test
    always_comb
    begin
        held_calc    = (btn_reg && !bd_reg) ? '0 : now_reg - ps_reg;
        since_repeat = now_reg - lr_reg;
        rep_due_calc = (since_repeat >= TIME_W'(repeat_ms_reg));
    end

    assign ge_short = (held_reg >= TIME_W'(short_ms_reg));
    assign ge_long  = (held_reg >= TIME_W'(long_ms_reg));
    assign ge_vlong = (held_reg >= TIME_W'(very_long_ms_reg));

    // Action decision; a later decision in the same sample overrides an earlier one
    always_comb
    begin
        act_next = ACT_NONE;
        bd_next  = bd_reg;
        ps_next  = ps_reg;
        fb_next  = fb_reg;
        fbl_next = fbl_reg;
        ld_next  = ld_reg;
        lr_next  = lr_reg;

        if (btn_reg && !bd_reg)
        begin
            // Press starts
            bd_next  = 1'b1;
            ps_next  = now_reg;
            fb_next  = 1'b0;
            fbl_next = 1'b0;
            ld_next  = DIR_NONE;
        end
        else if (!btn_reg && bd_reg)
        begin
            // Release: a short press with no back action gives select
            bd_next = 1'b0;
            if (!fb_reg && !fbl_reg && ge_short && !ge_long)
            begin
                act_next = ACT_SELECT;
            end
            fb_next  = 1'b0;
            fbl_next = 1'b0;
        end
        else if (btn_reg && bd_reg)
        begin
            // Still held: back, back2 and hold-direction repeats
            if (!fb_reg && ge_long)
            begin
                fb_next  = 1'b1;
                act_next = ACT_BACK;
            end
            if (!fbl_reg && ge_vlong)
            begin
                fbl_next = 1'b1;
                act_next = ACT_BACK2;
            end
            if (ge_long && dir_reg != DIR_NONE && rep_due_reg)
            begin
                lr_next  = now_reg;
                act_next = ACT_HOLD_BASE + ACT_W'(dir_reg);
            end
        end

        // Button up: edge plus auto-repeat of the stick direction
        if (!bd_next)
        begin
            if (dir_reg != DIR_NONE && dir_reg != ld_reg)
            begin
                act_next = ACT_W'(dir_reg);
                ld_next  = dir_reg;
                lr_next  = now_reg;
            end
            else if (dir_reg == DIR_NONE)
            begin
                ld_next = DIR_NONE;
            end
            else if (rep_due_reg)
            begin
                act_next = ACT_W'(dir_reg);
                lr_next  = now_reg;
            end
        end
    end

    // Press state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bd_reg  <= 1'b0;
            ps_reg  <= '0;
            fb_reg  <= 1'b0;
            fbl_reg <= 1'b0;
            ld_reg  <= DIR_NONE;
            lr_reg  <= '0;
        end
        else if (cmd.eval_en)
        begin
            bd_reg  <= bd_next;
            ps_reg  <= ps_next;
            fb_reg  <= fb_next;
            fbl_reg <= fbl_next;
            ld_reg  <= ld_next;
            lr_reg  <= lr_next;
        end
    end

    // Sample capture and per-sample working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg   <= s_tdata[AXW-1:0];
            y_reg   <= s_tdata[AXIS_W +: AXW];
            btn_reg <= s_tdata[2*AXIS_W];
            now_reg <= s_tdata[2*AXIS_W+1 +: TIME_W];
        end
        if (cmd.dir_en)
        begin
            dir_reg     <= dir_calc;
            held_reg    <= held_calc;
            rep_due_reg <= rep_due_calc;
        end
        if (cmd.eval_en)
        begin
            act_reg  <= act_next;
            pge1_reg <= ge_long;
            pge2_reg <= ge_vlong;
        end
        if (cmd.p1_save)
        begin
            p1_reg <= !bd_reg ? '0 : (pge1_reg ? PCT_FULL : quotient);
        end
        if (cmd.out_load)
        begin
            m_tdata <= {3'b000, p2_calc, p1_reg, dir_reg, act_reg};
        end
    end

    // Percentage division: held * 100 / limit, only used while held < limit
    assign dividend = DIVIDEND_W'(held_reg[MS_W-1:0]) * DIVIDEND_W'(PCT_FULL);
    assign divisor  = cmd.div_sel ? very_long_ms_reg : long_ms_reg;
    assign p2_calc  = !bd_reg ? '0 : (pge2_reg ? PCT_FULL : quotient);

    jpdq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .last     (div_last)
    );

    assign status.div_last = div_last;

endmodule

`default_nettype wire

// File: hdl/joystick_press_and_direction_qualifier.sv
// Top level of the joystick press and direction qualifier.
// Depends on jpdq_pkg, jpdq_ctrl, jpdq_dp and jpdq_div.
//
// Each input transaction is one joystick sample and yields exactly one output
// transaction carrying the action, the stick direction and two hold-progress
// percentages. No new sample is taken before the last one is in the output
// register, a pace set by the single seven-step percentage divider, which
// runs once for the long time and once for the very long time. A finished
// result waits in the output register while the next sample is accepted and
// worked on. Configuration writes are taken in any cycle and must only be
// issued while no sample is in flight.
`default_nettype none

module joystick_press_and_direction_qualifier #(
    parameter int ADC_BITS = 12
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [jpdq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [jpdq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Sample stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // raw_x[11:0], raw_y[23:12], button_pressed[24], now_ms[56:25], zero[63:57]
    input  wire logic [jpdq_pkg::S_TDATA_W-1:0]      s_tdata,
    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // action[3:0], direction[6:4], hold_progress[13:7],
    // hold_progress_long[20:14], zero[23:21]
    output logic      [jpdq_pkg::M_TDATA_W-1:0]      m_tdata
);
    import jpdq_pkg::*;

    jpdq_cmd_t    cmd;
    jpdq_status_t status;

    jpdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    jpdq_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// File: hdl/jpdq_checker.sv
// Port-level checks for the joystick press and direction qualifier, bound to
// the top level. Depends on jpdq_pkg.
`default_nettype none

module jpdq_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [jpdq_pkg::M_TDATA_W-1:0]  m_tdata
);
    import jpdq_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One sample at a time: the input side closes after a transaction.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a sample is in flight");

    // Direction codes stay within none..right.
    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:4] <= DIR_RIGHT)
        else $error("direction out of range");

    // Percentages never exceed full scale.
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[13:7] <= PCT_FULL && m_tdata[20:14] <= PCT_FULL)
        else $error("hold progress above 100");

    // Select comes only on release, when both progress figures read zero.
    a_select_released: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:0] == ACT_SELECT |-> m_tdata[20:7] == '0)
        else $error("select reported while button held");

endmodule

bind joystick_press_and_direction_qualifier jpdq_checker u_jpdq_checker (.*);

`default_nettype wire
